>>> hdl/scu_pkg.sv
// Shared types and constants for the stack calculator unit.
`default_nettype none

package scu_pkg;

  // Field widths of the channels
  localparam int CMD_W   = 3;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int DEPTH_W = 7;
  localparam int ITER_W  = $clog2(DATA_W);

  // Command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SUB  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MUL  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DIV  = 3'd5;

  // Decoded operation classes carried through the queue
  typedef logic [2:0] op_t;
  localparam op_t OP_PUSH = 3'd0;
  localparam op_t OP_POP  = 3'd1;
  localparam op_t OP_ADD  = 3'd2;
  localparam op_t OP_SUB  = 3'd3;
  localparam op_t OP_MUL  = 3'd4;
  localparam op_t OP_DIV  = 3'd5;
  localparam op_t OP_NOP  = 3'd7;

  // Status codes on the result channel
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNDER   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_DIVZERO = 2'd3;

  // One queued item between front and back
  typedef struct packed {
    op_t              op;
    logic [DATA_W-1:0] value;
  } qitem_t;

  // One result item
  typedef struct packed {
    logic [DATA_W-1:0]  value;
    logic [STAT_W-1:0]  status;
    logic [DEPTH_W-1:0] depth;
  } res_t;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> hdl/scu_cmd_if.sv
// Command channel: valid/ready handshake with command and push value.
`default_nettype none

interface scu_cmd_if import scu_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output command, output push_value, input ready);
  modport sink   (input valid, input command, input push_value, output ready);
endinterface

`default_nettype wire

>>> hdl/scu_res_if.sv
// Result channel: valid/ready handshake with value, status and depth.
`default_nettype none

interface scu_res_if import scu_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic [STAT_W-1:0]        status;
  logic [DEPTH_W-1:0]       depth;

  modport source (output valid, output result_value, output status, output depth,
                  input ready);
  modport sink   (input valid, input result_value, input status, input depth,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/scu_front.sv
// Front end: accepts commands, decodes them and holds them in a two-entry queue.
`default_nettype none

module scu_front import scu_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  scu_cmd_if.sink in_ch,
  output qitem_t q_item,
  output logic   q_valid,
  input  logic   q_pop
);

  qitem_t     fifo_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push_xfer;
  logic       pop_xfer;
  qitem_t     dec_item;

  // Map a command code to its operation class
  function automatic op_t decode_cmd(input logic [CMD_W-1:0] cmd);
    op_t op;
    case (cmd)
      CMD_PUSH: op = OP_PUSH;
      CMD_POP:  op = OP_POP;
      CMD_ADD:  op = OP_ADD;
      CMD_SUB:  op = OP_SUB;
      CMD_MUL:  op = OP_MUL;
      CMD_DIV:  op = OP_DIV;
      default:  op = OP_NOP;
    endcase
    return op;
  endfunction

  assign in_ch.ready = (fill_r != 2'd2);
  assign push_xfer   = in_ch.valid && in_ch.ready;
  assign q_valid     = (fill_r != 2'd0);
  assign pop_xfer    = q_pop && q_valid;
  assign q_item      = fifo_r[rd_ptr_r];

  assign dec_item.op    = decode_cmd(in_ch.command);
  assign dec_item.value = in_ch.push_value;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_xfer;
    rd_ptr_nxt = rd_ptr_r ^ pop_xfer;
    fill_nxt   = fill_r + {1'b0, push_xfer} - {1'b0, pop_xfer};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Store the decoded item on transfer
  always_ff @(posedge clk) begin
    if (push_xfer) begin
      fifo_r[wr_ptr_r] <= dec_item;
    end
  end

endmodule

`default_nettype wire

>>> hdl/scu_div.sv
// Signed 32-bit divider, truncating toward zero, one quotient bit per cycle.
`default_nettype none

module scu_div import scu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic [ITER_W-1:0] cnt_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] quo_r;
  logic [DATA_W-1:0] dvs_r;
  logic              neg_r;

  logic [DATA_W-1:0] a_mag;
  logic [DATA_W-1:0] b_mag;
  logic [DATA_W:0]   shifted;
  logic [DATA_W+1:0] trial;
  logic              fits;

  // Take magnitudes of the operands
  assign a_mag = req.dividend[DATA_W-1] ? (DATA_W'(0) - req.dividend) : req.dividend;
  assign b_mag = req.divisor[DATA_W-1]  ? (DATA_W'(0) - req.divisor)  : req.divisor;

  // Shift in the next dividend bit and try the subtract
  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_r};
  assign fits    = !trial[DATA_W+1];

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + ITER_W'(1);
        if (cnt_r == ITER_W'(DATA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Hold remainder, quotient and divisor
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= a_mag;
      dvs_r <= b_mag;
      neg_r <= req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
    end else if (busy_r) begin
      rem_r <= fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo_r <= {quo_r[DATA_W-2:0], fits};
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? (DATA_W'(0) - quo_r) : quo_r;

endmodule

`default_nettype wire

>>> hdl/scu_back.sv
// Back end: stack memory with cached top entry, execution sequencer and result register.
`default_nettype none

module scu_back import scu_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  qitem_t    q_item,
  input  logic      q_valid,
  output logic      q_pop,
  output div_req_t  div_req,
  input  div_rsp_t  div_rsp,
  scu_res_if.source out_ch
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  // Entries below the top live in memory; the top lives in tos_r
  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] tos_r, tos_nxt;
  op_t               op_r, op_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_r, out_nxt;

  logic              out_free;
  logic              mem_we;
  logic              mem_re;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  cnt_dec;
  logic [CNT_W-1:0]  cnt_dec2;
  logic              full;
  logic [DATA_W-1:0] alu_res;

  // Low bits of a count as reported depth
  function automatic logic [DEPTH_W-1:0] to_depth(input logic [CNT_W-1:0] c);
    logic [CNT_W+DEPTH_W-1:0] ext;
    ext = {{DEPTH_W{1'b0}}, c};
    return ext[DEPTH_W-1:0];
  endfunction

  assign out_free = !out_valid_r || out_ch.ready;
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign cnt_dec  = cnt_r - CNT_W'(1);
  assign cnt_dec2 = cnt_r - CNT_W'(2);
  assign full     = (cnt_r == CNT_W'(STACK_DEPTH));

  // Add, subtract or multiply top with next; product wraps to 32 bits
  always_comb begin
    case (op_r)
      OP_ADD:  alu_res = tos_r + rd_data_r;
      OP_SUB:  alu_res = tos_r - rd_data_r;
      default: alu_res = tos_r * rd_data_r;
    endcase
  end

  // Sequence one command at a time
  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    tos_nxt          = tos_r;
    op_nxt           = op_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_nxt          = out_r;
    q_pop            = 1'b0;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = tos_r;
    div_req.divisor  = rd_data_r;

    case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop  = 1'b1;
          op_nxt = q_item.op;
          case (q_item.op)
            OP_PUSH: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_nxt = '{value: '0, status: ST_FULL, depth: to_depth(cnt_r)};
              end else begin
                mem_we  = (cnt_r != '0);
                tos_nxt = q_item.value;
                cnt_nxt = cnt_inc;
                out_nxt = '{value: '0, status: ST_OK, depth: to_depth(cnt_inc)};
              end
            end
            OP_POP: begin
              if (cnt_r == '0) begin
                out_valid_nxt = 1'b1;
                out_nxt = '{value: '0, status: ST_UNDER, depth: to_depth(cnt_r)};
              end else if (cnt_r == CNT_W'(1)) begin
                out_valid_nxt = 1'b1;
                cnt_nxt = '0;
                out_nxt = '{value: tos_r, status: ST_OK, depth: to_depth('0)};
              end else begin
                mem_re    = 1'b1;
                state_nxt = S_READ;
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
              if (cnt_r < CNT_W'(2)) begin
                out_valid_nxt = 1'b1;
                out_nxt = '{value: '0, status: ST_UNDER, depth: to_depth(cnt_r)};
              end else begin
                mem_re    = 1'b1;
                state_nxt = S_READ;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_nxt = '{value: '0, status: ST_OK, depth: to_depth(cnt_r)};
            end
          endcase
        end
      end

      S_READ: begin
        state_nxt = S_IDLE;
        case (op_r)
          OP_POP: begin
            out_valid_nxt = 1'b1;
            tos_nxt = rd_data_r;
            cnt_nxt = cnt_dec;
            out_nxt = '{value: tos_r, status: ST_OK, depth: to_depth(cnt_dec)};
          end
          OP_DIV: begin
            if (rd_data_r == '0) begin
              out_valid_nxt = 1'b1;
              out_nxt = '{value: '0, status: ST_DIVZERO, depth: to_depth(cnt_r)};
            end else begin
              div_req.start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
            tos_nxt = alu_res;
            cnt_nxt = cnt_dec;
            out_nxt = '{value: alu_res, status: ST_OK, depth: to_depth(cnt_dec)};
          end
        endcase
      end

      S_DIV: begin
        if (div_rsp.done) begin
          out_valid_nxt = 1'b1;
          tos_nxt   = div_rsp.quotient;
          cnt_nxt   = cnt_dec;
          out_nxt   = '{value: div_rsp.quotient, status: ST_OK, depth: to_depth(cnt_dec)};
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    tos_r <= tos_nxt;
    op_r  <= op_nxt;
    out_r <= out_nxt;
  end

  // Spill the old top on push; fetch the entry under the top
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_dec[ADDR_W-1:0]] <= tos_r;
    end
    if (mem_re) begin
      rd_data_r <= mem[cnt_dec2[ADDR_W-1:0]];
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_r.value;
  assign out_ch.status       = out_r.status;
  assign out_ch.depth        = out_r.depth;

endmodule

`default_nettype wire

>>> hdl/stack_calculator_unit_top.sv
// Top level of the stack calculator unit: front queue, execution back end, divider.
//
//   Channel  Dir  Handshake      Payload
//   in_ch    in   valid/ready    command[2:0], push_value[31:0] signed
//   out_ch   out  valid/ready    result_value[31:0] signed, status[1:0], depth[6:0]
//
// Push, unused codes, underflows and a pop of the last entry finish in the back end on dequeue;
// other pops, add, sub, mul and divide by zero also wait for the registered memory read.
// Div goes through dequeue, the memory read, 32 steps of the radix-2 divider and finish.
// The front queue holds two items so commands are taken while the back end works.
// Reset (rst_n low, synchronous) empties the stack and queue; memory is not cleared.
// A stalled result holds in the output register and blocks the back end only.
`default_nettype none

module stack_calculator_unit_top import scu_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  scu_cmd_if.sink   in_ch,
  scu_res_if.source out_ch
);

  localparam logic [DEPTH_W-1:0] FULL_DEPTH = DEPTH_W'(STACK_DEPTH);

  qitem_t   q_item;
  logic     q_valid;
  logic     q_pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  scu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  scu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  scu_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .div_req (div_req),
    .div_rsp (div_rsp),
    .out_ch  (out_ch)
  );

  // Divider is only started when idle
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // Divider completion is a single-cycle pulse
  a_div_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |=> !div_rsp.done)
    else $error("divider done held longer than one cycle");

  // Back end only dequeues a present item
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("dequeue from empty command queue");

  // A dropped push reports a full stack
  a_full_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_FULL) |-> (out_ch.depth == FULL_DEPTH))
    else $error("overflow status with stack not full");

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench, stack calculator unit: directed and random commands vs. stack predictor.
module tb_top import scu_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH = 64;
  localparam int RAND_ITEMS  = 700;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 60;
  localparam int MAX_REPORTS = 10;
  localparam int IDLE_PCT    = 20;
  localparam int QUIET_START = 300;
  localparam int QUIET_STOP  = 420;

  // Codes the block decodes as no-ops
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] WORD_NEG1 = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [DATA_W-1:0] value;
  } cmd_item_t;

  logic clk = 1'b0;
  logic rst_n;

  scu_cmd_if in_ch();
  scu_res_if out_ch();

  stack_calculator_unit_top #(.STACK_DEPTH(STACK_DEPTH)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  cmd_item_t         cmd_q[$];
  res_t              expect_q[$];
  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  int                stack_cnt;
  int                err_cnt;
  int                in_count;
  int                stall_cycles;
  int                idle_pct;
  logic              in_taken;
  cmd_item_t         drv_item;

  // Signed division truncating toward zero; the most negative word over -1 wraps
  function automatic logic [DATA_W-1:0] trunc_quot(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] ma, mb, q;
    ma = a[DATA_W-1] ? -a : a;
    mb = b[DATA_W-1] ? -b : b;
    q  = ma / mb;
    if (a[DATA_W-1] ^ b[DATA_W-1]) q = -q;
    return q;
  endfunction

  // Apply one command to the shadow stack and return the result it yields
  function automatic res_t stack_apply(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] word);
    res_t              r;
    logic [DATA_W-1:0] a, b;
    r.value  = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_PUSH: begin
        if (stack_cnt < STACK_DEPTH) begin
          stack_mem[stack_cnt] = word;
          stack_cnt++;
        end else begin
          r.status = ST_FULL;
        end
      end
      CMD_POP: begin
        if (stack_cnt > 0) begin
          stack_cnt--;
          r.value = stack_mem[stack_cnt];
        end else begin
          r.status = ST_UNDER;
        end
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
        if (stack_cnt >= 2) begin
          a = stack_mem[stack_cnt-1];
          b = stack_mem[stack_cnt-2];
          if (cmd == CMD_DIV && b == '0) begin
            r.status = ST_DIVZERO;
          end else begin
            case (cmd)
              CMD_ADD: r.value = a + b;
              CMD_SUB: r.value = a - b;
              CMD_MUL: r.value = a * b;
              default: r.value = trunc_quot(a, b);
            endcase
            stack_cnt--;
            stack_mem[stack_cnt-1] = r.value;
          end
        end else begin
          r.status = ST_UNDER;
        end
      end
      default: ;
    endcase
    r.depth = DEPTH_W'(stack_cnt);
    return r;
  endfunction

  // Operand mix weighted toward the corner words and small values
  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return WORD_NEG1;
      2: return WORD_MIN;
      3: return WORD_MAX;
      4, 5: return DATA_W'($urandom_range(16)) - 32'd8;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_cmd(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] word);
    cmd_item_t it;
    it.command = cmd;
    it.value   = word;
    cmd_q.push_back(it);
  endtask

  // Hold idling off for a stretch of transfers in the middle of the run
  always_comb idle_pct = (in_count >= QUIET_START && in_count < QUIET_STOP) ? 0 : IDLE_PCT;

  // Command driver and result backpressure, updated on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      if (!in_ch.valid || in_taken) begin
        if (cmd_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          drv_item          = cmd_q.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.command    <= drv_item.command;
          in_ch.push_value <= drv_item.value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Predict on each command transfer, check each result transfer, watch for hangs
  always @(posedge clk) begin
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        expect_q.push_back(stack_apply(in_ch.command, in_ch.push_value));
        in_count++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expect_q.size() == 0) begin
          if (err_cnt < MAX_REPORTS)
            $display("%0t: result with nothing expected: value %h status %0d depth %0d",
                     $realtime, out_ch.result_value, out_ch.status, out_ch.depth);
          err_cnt++;
        end else begin
          res_t want;
          want = expect_q.pop_front();
          if (out_ch.result_value !== want.value || out_ch.status !== want.status ||
              out_ch.depth !== want.depth) begin
            if (err_cnt < MAX_REPORTS)
              $display("%0t: mismatch: expected value %h status %0d depth %0d, got %h %0d %0d",
                       $realtime, want.value, want.status, want.depth,
                       out_ch.result_value, out_ch.status, out_ch.depth);
            err_cnt++;
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int phase_len, push_pct, n_rand;
    logic [CMD_W-1:0] cmd;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_PUSH;
    in_ch.push_value = '0;
    out_ch.ready     = 1'b0;
    in_taken         = 1'b0;
    stack_cnt        = 0;
    err_cnt          = 0;
    in_count         = 0;
    stall_cycles     = 0;

    // Directed: underflows, no-op codes, divide by zero, wraps of div and mul
    queue_cmd(CMD_POP, pick_word());
    queue_cmd(CMD_ADD, '0);
    queue_cmd(CMD_SPARE_LO, WORD_NEG1);
    queue_cmd(CMD_PUSH, 32'd5);
    queue_cmd(CMD_MUL, '0);
    queue_cmd(CMD_POP, '0);
    queue_cmd(CMD_PUSH, '0);
    queue_cmd(CMD_PUSH, WORD_MAX);
    queue_cmd(CMD_DIV, '0);
    queue_cmd(CMD_SUB, '0);
    queue_cmd(CMD_PUSH, WORD_NEG1);
    queue_cmd(CMD_PUSH, WORD_MIN);
    queue_cmd(CMD_DIV, '0);
    queue_cmd(CMD_ADD, '0);
    queue_cmd(CMD_PUSH, 32'd3);
    queue_cmd(CMD_PUSH, -32'sd7);
    queue_cmd(CMD_DIV, '0);
    queue_cmd(CMD_MUL, '0);
    queue_cmd(CMD_PUSH, WORD_MIN);
    queue_cmd(CMD_PUSH, WORD_MAX);
    queue_cmd(CMD_MUL, WORD_NEG1);
    queue_cmd(CMD_SPARE_HI, '0);
    queue_cmd(CMD_POP, '0);
    queue_cmd(CMD_POP, '0);

    // Random: phases that fill, drain or churn the stack
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      phase_len = $urandom_range(40, 90);
      case ($urandom_range(2))
        0: push_pct = 90;
        1: push_pct = 15;
        default: push_pct = 50;
      endcase
      repeat (phase_len) begin
        if ($urandom_range(99) < push_pct) begin
          queue_cmd(CMD_PUSH, pick_word());
          n_rand++;
        end else if ($urandom_range(29) == 0) begin
          cmd = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
          queue_cmd(cmd, $urandom());
        end else begin
          case ($urandom_range(4))
            0: cmd = CMD_POP;
            1: cmd = CMD_ADD;
            2: cmd = CMD_SUB;
            3: cmd = CMD_MUL;
            default: cmd = CMD_DIV;
          endcase
          queue_cmd(cmd, $urandom());
          n_rand++;
        end
      end
    end

    // Hold reset, then release on a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Wait for every command to transfer and every result to return
    while (cmd_q.size() > 0 || in_ch.valid) @(posedge clk);
    while (expect_q.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_cnt == 0 && expect_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/scu_pkg.sv
hdl/scu_cmd_if.sv
hdl/scu_res_if.sv
hdl/scu_front.sv
hdl/scu_div.sv
hdl/scu_back.sv
hdl/stack_calculator_unit_top.sv
test/tb_top.sv
